[design/three_axis_rate_pid_with_level_modes_core_macros.svh]
// Assertion macros shared by the rate PID core modules.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef THREE_AXIS_RATE_PID_WITH_LEVEL_MODES_CORE_MACROS_SVH
`define THREE_AXIS_RATE_PID_WITH_LEVEL_MODES_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TARP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tarp assertion failed");

// Next-cycle implication, checked outside reset.
`define TARP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tarp assertion failed");

`endif

[design/tarp_pkg.sv]
// Types, constants and helpers for the three-axis rate PID core.
// No dependencies.
package tarp_pkg;

    localparam logic [8:0]  RATE_OFFSET = 9'd27;
    localparam logic [15:0] RECIP_DIVIDEND = 16'hFFFF;
    localparam int          CMD_LIMIT = 500;
    // Division by ten of a 16-bit magnitude as (x * 52429) >> 19, exact for 16 bits.
    localparam logic [17:0] ANGLE_RECIP = 18'd52429;
    localparam int          ANGLE_RECIP_SHIFT = 19;

    localparam logic [2:0] CFG_RATE_P     = 3'd0;
    localparam logic [2:0] CFG_RATE_I     = 3'd1;
    localparam logic [2:0] CFG_RATE_D     = 3'd2;
    localparam logic [2:0] CFG_LEVEL      = 3'd3;
    localparam logic [2:0] CFG_RP_RATES   = 3'd4;
    localparam logic [2:0] CFG_YAW_RATE   = 3'd5;
    localparam logic [2:0] CFG_TRIMS      = 3'd6;

    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;
    localparam logic [1:0] AXIS_NONE  = 2'd3;

    typedef struct packed {
        logic [23:0] rate_p;
        logic [23:0] rate_i;
        logic [23:0] rate_d;
        logic [15:0] level;
        logic [15:0] rp_rates;
        logic [7:0]  yaw_rate;
        logic [31:0] trims;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         axis_select;
        logic               axis_ok;
        logic signed [9:0]  stick_command;
        logic signed [15:0] gyro_rate;
        logic signed [16:0] angle_num;
        logic [15:0]        loop_time;
        logic [11:0]        d_divisor;
        logic               level_mode;
        logic               blend_mode;
    } t_item;

    function automatic logic [7:0] gain_byte(input logic [23:0] r, input logic [1:0] ax);
        logic [7:0] g;
        unique case (ax)
            AXIS_ROLL:  g = r[7:0];
            AXIS_PITCH: g = r[15:8];
            default:    g = r[23:16];
        endcase
        return g;
    endfunction

endpackage

[design/tarp_in_if.sv]
// Input sample channel of the rate PID core: valid, ready and one axis sample.
// No dependencies.
interface tarp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_select;
    logic signed [9:0]  stick_command;
    logic signed [15:0] gyro_rate;
    logic signed [11:0] tilt_angle;
    logic signed [10:0] gps_correction;
    logic [15:0]        loop_time;
    logic               level_mode;
    logic               blend_mode;

    modport source (output valid, axis_select, stick_command, gyro_rate, tilt_angle,
                    gps_correction, loop_time, level_mode, blend_mode, input ready);
    modport sink (input valid, axis_select, stick_command, gyro_rate, tilt_angle,
                  gps_correction, loop_time, level_mode, blend_mode, output ready);
endinterface

[design/tarp_out_if.sv]
// Result channel of the rate PID core: valid, ready, axis and drive value.
// No dependencies.
interface tarp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_done;
    logic signed [15:0] pid_drive;

    modport source (output valid, axis_done, pid_drive, input ready);
    modport sink (input valid, axis_done, pid_drive, output ready);
endinterface

[design/tarp_front.sv]
// Front end: accepts input beats, classifies the axis and prepares the
// angle numerator and D divisor. Depends on tarp_pkg and tarp_in_if.
module tarp_front #(
    parameter int NUM_AXES = 3
) (
    input  tarp_pkg::t_cfg i_cfg,
    tarp_in_if.sink        i_item,
    input  logic           i_full,
    output logic           o_push,
    output tarp_pkg::t_item o_item
);
    logic signed [11:0] cmd_sum;
    logic signed [11:0] cmd_clamped;
    logic signed [15:0] trim;
    logic [11:0]        loop_div;

    assign i_item.ready = !i_full;
    assign o_push = i_item.valid && !i_full;

    always_comb begin
        cmd_sum = 12'(i_item.stick_command) + 12'(i_item.gps_correction);
        if (cmd_sum > 12'sd500) begin
            cmd_clamped = 12'(tarp_pkg::CMD_LIMIT);
        end else if (cmd_sum < -12'sd500) begin
            cmd_clamped = -12'(tarp_pkg::CMD_LIMIT);
        end else begin
            cmd_clamped = cmd_sum;
        end
        trim = (i_item.axis_select == tarp_pkg::AXIS_PITCH) ? $signed(i_cfg.trims[31:16])
                                                             : $signed(i_cfg.trims[15:0]);
        loop_div = i_item.loop_time[15:4];

        o_item.axis_select  = i_item.axis_select;
        o_item.axis_ok      = (i_item.axis_select != tarp_pkg::AXIS_NONE) &&
                              (32'(i_item.axis_select) < NUM_AXES);
        o_item.stick_command = i_item.stick_command;
        o_item.gyro_rate    = i_item.gyro_rate;
        o_item.angle_num    = 17'(cmd_clamped) - 17'(i_item.tilt_angle) + 17'(trim);
        o_item.loop_time    = i_item.loop_time;
        o_item.d_divisor    = (loop_div == 12'd0) ? 12'd1 : loop_div;
        o_item.level_mode   = i_item.level_mode;
        o_item.blend_mode   = i_item.blend_mode;
    end
endmodule

[design/tarp_fifo.sv]
// Two-entry queue between the front end and the back end.
// Depends on tarp_pkg and the assertion macro header.
`include "three_axis_rate_pid_with_level_modes_core_macros.svh"
module tarp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tarp_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tarp_pkg::t_item o_head
);
    tarp_pkg::t_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `TARP_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= 2'd2)
    `TARP_ASSERT_IMP(a_no_pop_empty, i_pop, r_cnt != 2'd0)
    `TARP_ASSERT_IMP(a_no_push_full, i_push, r_cnt != 2'd2)
endmodule

[design/tarp_div.sv]
// Restoring divider, one quotient bit per cycle, 16-bit dividend, 12-bit divisor.
// No dependencies.
module tarp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [11:0] i_divisor,
    output logic        o_busy,
    output logic [15:0] o_quotient
);
    logic [11:0] r_rem;
    logic [15:0] r_q;
    logic [11:0] r_dvs;
    logic [4:0]  r_cnt;
    logic [12:0] rem_sh;
    logic        ge;

    assign o_busy = (r_cnt != 5'd0);
    assign o_quotient = r_q;
    assign rem_sh = {r_rem, r_q[15]};
    assign ge = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 12'd0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_rem <= ge ? 12'(rem_sh - {1'b0, r_dvs}) : rem_sh[11:0];
            r_q   <= {r_q[14:0], ge};
        end
    end
endmodule

[design/tarp_back.sv]
// Back end: sequences the rate demand, P, I and D terms over a shared
// registered multiplier, plus a divider for the D term. Depends on tarp_pkg, tarp_div, tarp_out_if.
`include "three_axis_rate_pid_with_level_modes_core_macros.svh"
module tarp_back #(
    parameter int NUM_AXES = 3,
    parameter int INTEGRATOR_LIMIT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tarp_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  tarp_pkg::t_item i_head,
    output logic            o_pop,
    tarp_out_if.source      o_result
);
    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int IW = $clog2(INTEGRATOR_LIMIT) + 15;
    localparam int RS = tarp_pkg::ANGLE_RECIP_SHIFT;
    localparam logic signed [33:0] LIM = 34'(INTEGRATOR_LIMIT) * 34'sd8192;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_EMUL = 15'b000000000000010,
        S_EQ   = 15'b000000000000100,
        S_DEM1 = 15'b000000000001000,
        S_DEM2 = 15'b000000000010000,
        S_ERR  = 15'b000000000100000,
        S_P    = 15'b000000001000000,
        S_I1   = 15'b000000010000000,
        S_I2   = 15'b000000100000000,
        S_I3   = 15'b000001000000000,
        S_DW   = 15'b000010000000000,
        S_D2   = 15'b000100000000000,
        S_D3   = 15'b001000000000000,
        S_D4   = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state             r_state;
    tarp_pkg::t_item    r_cur;
    logic signed [12:0] r_e;
    logic signed [17:0] r_dem;
    logic signed [17:0] r_err;
    logic [15:0]        r_p;
    logic [15:0]        r_i;
    logic [15:0]        r_d;
    logic signed [31:0] r_dsum;
    logic signed [49:0] r_prod;
    logic signed [IW-1:0] r_integ [NUM_AXES];
    logic signed [17:0] r_prev [NUM_AXES];
    logic signed [29:0] r_h1 [NUM_AXES];
    logic signed [29:0] r_h2 [NUM_AXES];
    logic               r_out_valid;
    logic [1:0]         r_out_ax;
    logic [15:0]        r_out_drive;

    logic [AXW-1:0]     ai;
    logic [1:0]         ax;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic               div_start;
    logic [15:0]        div_dividend;
    logic [11:0]        div_divisor;
    logic               div_busy;
    logic [15:0]        div_q;
    logic [16:0]        cur_neg_num;
    logic [15:0]        cur_mag;
    logic               use_hz;
    logic signed [18:0] err_full;
    logic signed [33:0] isum;
    logic signed [33:0] iclamp;
    logic signed [29:0] delta;
    logic               out_free;
    logic [8:0]         rp_rate;
    logic [8:0]         yaw_rate;

    assign ai = r_cur.axis_select[AXW-1:0];
    assign ax = r_cur.axis_select;
    assign out_free = !r_out_valid || o_result.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.axis_done = r_out_ax;
    assign o_result.pid_drive = r_out_drive;
    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign cur_neg_num = 17'(-r_cur.angle_num);
    assign cur_mag = r_cur.angle_num[16] ? cur_neg_num[15:0] : r_cur.angle_num[15:0];
    assign use_hz = r_cur.blend_mode && !r_cur.level_mode && (ax != tarp_pkg::AXIS_YAW);
    assign rp_rate = 9'(tarp_pkg::gain_byte({8'd0, i_cfg.rp_rates}, ax)) + tarp_pkg::RATE_OFFSET;
    assign yaw_rate = 9'(i_cfg.yaw_rate) + tarp_pkg::RATE_OFFSET;

    // The D-term reciprocal starts as the sample is popped and runs beside the
    // multiply sequence.
    assign div_start = o_pop && i_head.axis_ok;
    assign div_dividend = tarp_pkg::RECIP_DIVIDEND;
    assign div_divisor = i_head.d_divisor;

    tarp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_comb begin
        mul_a = 32'sd0;
        mul_b = 18'sd0;
        unique case (r_state)
            S_EMUL: begin
                mul_a = $signed({16'd0, cur_mag});
                mul_b = $signed(tarp_pkg::ANGLE_RECIP);
            end
            S_DEM1: begin
                if (ax == tarp_pkg::AXIS_YAW) begin
                    mul_a = $signed({23'd0, yaw_rate});
                    mul_b = 18'(r_cur.stick_command);
                end else if (r_cur.level_mode) begin
                    mul_a = 32'(r_e);
                    mul_b = $signed({10'd0, i_cfg.level[7:0]});
                end else begin
                    mul_a = $signed({23'd0, rp_rate});
                    mul_b = 18'(r_cur.stick_command);
                end
            end
            S_DEM2: begin
                mul_a = 32'(r_e);
                mul_b = $signed({10'd0, i_cfg.level[15:8]});
            end
            S_P: begin
                mul_a = 32'(r_err);
                mul_b = $signed({10'd0, tarp_pkg::gain_byte(i_cfg.rate_p, ax)});
            end
            S_I1: begin
                mul_a = 32'(r_err);
                mul_b = $signed({2'd0, r_cur.loop_time});
            end
            S_I2: begin
                mul_a = r_prod[42:11];
                mul_b = $signed({10'd0, tarp_pkg::gain_byte(i_cfg.rate_i, ax)});
            end
            S_DW: begin
                mul_a = 32'(r_err) - 32'(r_prev[ai]);
                mul_b = $signed({2'd0, div_q});
            end
            S_D3: begin
                mul_a = r_dsum;
                mul_b = $signed({10'd0, tarp_pkg::gain_byte(i_cfg.rate_d, ax)});
            end
            default: begin
                mul_a = 32'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    always_comb begin
        err_full = 19'(r_dem) + (use_hz ? 19'($signed(r_prod[25:8])) : 19'sd0)
                   - 19'(r_cur.gyro_rate);
        isum = 34'(r_integ[ai]) + r_prod[33:0];
        if (isum > LIM) begin
            iclamp = LIM;
        end else if (isum < -LIM) begin
            iclamp = -LIM;
        end else begin
            iclamp = isum;
        end
        delta = r_prod[35:6];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_cur <= i_head;
                r_p <= 16'd0;
                r_i <= 16'd0;
                r_d <= 16'd0;
            end
            S_EQ: begin
                r_e <= r_cur.angle_num[16] ? -13'(r_prod[RS+15:RS]) : 13'(r_prod[RS+15:RS]);
            end
            S_DEM2: begin
                r_dem <= (ax == tarp_pkg::AXIS_YAW) ? r_prod[22:5] : r_prod[21:4];
            end
            S_ERR: begin
                r_err <= err_full[17:0];
            end
            S_I1: begin
                r_p <= r_prod[22:7];
            end
            S_D2: begin
                r_dsum <= 32'(r_h1[ai]) + 32'(r_h2[ai]) + 32'(delta);
            end
            S_D4: begin
                r_d <= r_prod[23:8];
            end
            default: begin
            end
        endcase
        if (r_state == S_I3) begin
            r_i <= 16'(iclamp >>> 13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_integ[k] <= '0;
                r_prev[k] <= '0;
                r_h1[k] <= '0;
                r_h2[k] <= '0;
            end
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_head.axis_ok ? S_EMUL : S_OUT;
                    end
                end
                S_EMUL: r_state <= S_EQ;
                S_EQ:   r_state <= S_DEM1;
                S_DEM1: r_state <= S_DEM2;
                S_DEM2: r_state <= S_ERR;
                S_ERR:  r_state <= S_P;
                S_P:    r_state <= S_I1;
                S_I1:   r_state <= S_I2;
                S_I2:   r_state <= S_I3;
                S_I3: begin
                    r_integ[ai] <= IW'(iclamp);
                    r_state <= S_DW;
                end
                S_DW: begin
                    if (!div_busy) begin
                        r_prev[ai] <= r_err;
                        r_state <= S_D2;
                    end
                end
                S_D2: begin
                    r_h2[ai] <= r_h1[ai];
                    r_h1[ai] <= delta;
                    r_state <= S_D3;
                end
                S_D3: r_state <= S_D4;
                S_D4: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_out_ax <= ax;
                        r_out_drive <= r_p + r_i + r_d;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TARP_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(r_state))
    `TARP_ASSERT_IMP(a_div_idle_on_start, div_start, !div_busy)
    `TARP_ASSERT_NXT(a_pop_moves_on, o_pop, (r_state == S_EMUL) || (r_state == S_OUT))
endmodule

[design/three_axis_rate_pid_with_level_modes_core.sv]
// Channel     Dir  Handshake      Payload
// i_item      in   valid/ready    axis, stick, gyro, tilt, gps, loop time, mode flags
// o_result    out  valid/ready    axis_done, pid_drive
// cfg port    in   i_cfg_we       i_cfg_idx, i_cfg_data
// In the back end a sample runs from its pop to its result beat through the state
// sequence, and the D step waits on the 16-step reciprocal division; an out-of-range
// axis goes from idle straight to the output state.
// Reset is synchronous; it clears config, state, queue, integrators, previous errors and delta histories.
// A two-entry queue lets the front accept samples while the back end works or
// while a finished result waits on o_result.
// Depends on tarp_pkg, the channel interfaces, tarp_front, tarp_fifo, tarp_back.
module three_axis_rate_pid_with_level_modes_core #(
    parameter int NUM_AXES = 3,
    parameter int INTEGRATOR_LIMIT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tarp_in_if.sink     i_item,
    tarp_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    tarp_pkg::t_cfg  r_cfg;
    tarp_pkg::t_item push_item;
    tarp_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tarp_pkg::CFG_RATE_P:   r_cfg.rate_p <= i_cfg_data[23:0];
                tarp_pkg::CFG_RATE_I:   r_cfg.rate_i <= i_cfg_data[23:0];
                tarp_pkg::CFG_RATE_D:   r_cfg.rate_d <= i_cfg_data[23:0];
                tarp_pkg::CFG_LEVEL:    r_cfg.level <= i_cfg_data[15:0];
                tarp_pkg::CFG_RP_RATES: r_cfg.rp_rates <= i_cfg_data[15:0];
                tarp_pkg::CFG_YAW_RATE: r_cfg.yaw_rate <= i_cfg_data[7:0];
                tarp_pkg::CFG_TRIMS:    r_cfg.trims <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tarp_front #(
        .NUM_AXES (NUM_AXES)
    ) u_front (
        .i_cfg  (r_cfg),
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    tarp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_item)
    );

    tarp_back #(
        .NUM_AXES         (NUM_AXES),
        .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_head   (head_item),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule

[test/tarp_tb_if.sv]
`timescale 1ns / 1ps
// Testbench types: one input sample and one expected result beat.
// No dependencies.
package tarp_tb_pkg;

    typedef struct packed {
        logic [1:0]         axis_select;
        logic signed [9:0]  stick_command;
        logic signed [15:0] gyro_rate;
        logic signed [11:0] tilt_angle;
        logic signed [10:0] gps_correction;
        logic [15:0]        loop_time;
        logic               level_mode;
        logic               blend_mode;
    } t_sample;

    typedef struct packed {
        logic [1:0]         axis_done;
        logic signed [15:0] pid_drive;
    } t_drive;
endpackage

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the three-axis rate PID core: random and directed samples,
// a built-in PID predictor and an in-order result scoreboard.
// Depends on tarp_pkg, tarp_tb_pkg, tarp_in_if, tarp_out_if and the core.
module testbench;

    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] CFG_NONE = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    tarp_in_if  smp_ch();
    tarp_out_if drv_ch();

    three_axis_rate_pid_with_level_modes_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(smp_ch.sink), .o_result(drv_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tarp_tb_pkg::t_sample sample_q[$];
    tarp_tb_pkg::t_drive  drive_q[$];
    int      errors = 0;
    int      stall_cycles = 0;
    bit      calm = 0;
    int      hold_cycles = 0;
    bit      in_taken = 0;

    longint  integ[3], prev_err[3], hist1[3], hist2[3];
    logic [23:0] g_p, g_i, g_d;
    logic [15:0] g_level, g_rp;
    logic [7:0]  g_yaw;
    logic [31:0] g_trims;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic tarp_tb_pkg::t_drive predict_drive(tarp_tb_pkg::t_sample s);
        tarp_tb_pkg::t_drive r;
        longint stick, demand, err, pt, it, dt, delta, dsum, dv, cmd, trim, e, lp, lim;
        int ax;
        r.axis_done = s.axis_select;
        r.pid_drive = 0;
        ax = s.axis_select;
        if (s.axis_select == tarp_pkg::AXIS_NONE) return r;
        stick = s.stick_command;
        lp = s.loop_time;
        if (s.axis_select == tarp_pkg::AXIS_YAW) begin
            demand = floor_shift((longint'(g_yaw) + 27) * stick, 5);
        end else begin
            cmd = stick + longint'(s.gps_correction);
            if (cmd > tarp_pkg::CMD_LIMIT) cmd = tarp_pkg::CMD_LIMIT;
            if (cmd < -tarp_pkg::CMD_LIMIT) cmd = -tarp_pkg::CMD_LIMIT;
            trim = (s.axis_select == tarp_pkg::AXIS_ROLL) ? longint'($signed(g_trims[15:0]))
                                                           : longint'($signed(g_trims[31:16]));
            e = (cmd - longint'(s.tilt_angle) + trim) / 10;
            if (s.level_mode) begin
                demand = floor_shift(e * longint'(g_level[7:0]), 4);
            end else begin
                demand = floor_shift((longint'(tarp_pkg::gain_byte({8'd0, g_rp},
                                     s.axis_select)) + 27) * stick, 4);
                if (s.blend_mode) demand += floor_shift(e * longint'(g_level[15:8]), 8);
            end
        end
        err = demand - longint'(s.gyro_rate);
        pt = floor_shift(err * longint'(tarp_pkg::gain_byte(g_p, s.axis_select)), 7);
        lim = 256 * 8192;
        integ[ax] += floor_shift(err * lp, 11) *
                     longint'(tarp_pkg::gain_byte(g_i, s.axis_select));
        if (integ[ax] > lim) integ[ax] = lim;
        if (integ[ax] < -lim) integ[ax] = -lim;
        it = floor_shift(integ[ax], 13);
        delta = err - prev_err[ax];
        prev_err[ax] = err;
        dv = lp >> 4;
        if (dv == 0) dv = 1;
        delta = floor_shift(delta * (65535 / dv), 6);
        dsum = hist1[ax] + hist2[ax] + delta;
        hist2[ax] = hist1[ax];
        hist1[ax] = delta;
        dt = floor_shift(dsum * longint'(tarp_pkg::gain_byte(g_d, s.axis_select)), 8);
        r.pid_drive = 16'(pt + it + dt);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 0;
        case (idx)
            tarp_pkg::CFG_RATE_P:   g_p = val[23:0];
            tarp_pkg::CFG_RATE_I:   g_i = val[23:0];
            tarp_pkg::CFG_RATE_D:   g_d = val[23:0];
            tarp_pkg::CFG_LEVEL:    g_level = val[15:0];
            tarp_pkg::CFG_RP_RATES: g_rp = val[15:0];
            tarp_pkg::CFG_YAW_RATE: g_yaw = val[7:0];
            tarp_pkg::CFG_TRIMS:    g_trims = val;
            default: ;
        endcase
    endtask

    function automatic tarp_tb_pkg::t_sample random_sample();
        tarp_tb_pkg::t_sample s;
        s.axis_select = ($urandom_range(0, 19) == 0) ? tarp_pkg::AXIS_NONE
                                                      : 2'($urandom_range(0, 2));
        s.stick_command = 10'($signed($urandom_range(0, 1000)) - 500);
        s.gyro_rate = 16'($urandom);
        s.tilt_angle = 12'($signed($urandom_range(0, 3600)) - 1800);
        s.gps_correction = 11'($signed($urandom_range(0, 2000)) - 1000);
        case ($urandom_range(0, 3))
            0: s.loop_time = 16'($urandom_range(0, 40));
            1: s.loop_time = 16'($urandom);
            default: s.loop_time = 16'($urandom_range(1000, 4000));
        endcase
        s.level_mode = 1'($urandom);
        s.blend_mode = 1'($urandom);
        return s;
    endfunction

    function automatic tarp_tb_pkg::t_sample make_sample(logic [1:0] ax, int st, int gy,
                                                         int ti, int gp, int lt, bit am,
                                                         bit hm);
        tarp_tb_pkg::t_sample s;
        s.axis_select = ax; s.stick_command = 10'(st); s.gyro_rate = 16'(gy);
        s.tilt_angle = 12'(ti); s.gps_correction = 11'(gp); s.loop_time = 16'(lt);
        s.level_mode = am; s.blend_mode = hm;
        return s;
    endfunction

    task automatic wait_idle();
        while (sample_q.size() != 0 || drive_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_regs();
        write_reg(tarp_pkg::CFG_RATE_P, $urandom);
        write_reg(tarp_pkg::CFG_RATE_I, $urandom);
        write_reg(tarp_pkg::CFG_RATE_D, $urandom);
        write_reg(tarp_pkg::CFG_LEVEL, $urandom);
        write_reg(tarp_pkg::CFG_RP_RATES, $urandom);
        write_reg(tarp_pkg::CFG_YAW_RATE, $urandom);
        write_reg(tarp_pkg::CFG_TRIMS, $urandom);
    endtask

    // Driver: offers the head of the pending queue until it is taken, with idle bursts.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 0;
        end else if (smp_ch.valid && !in_taken) begin
        end else begin
            if (in_taken) void'(sample_q.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                smp_ch.valid <= 0;
            end else if (sample_q.size() > 0) begin
                tarp_tb_pkg::t_sample s;
                s = sample_q[0];
                smp_ch.valid <= 1;
                smp_ch.axis_select <= s.axis_select;
                smp_ch.stick_command <= s.stick_command;
                smp_ch.gyro_rate <= s.gyro_rate;
                smp_ch.tilt_angle <= s.tilt_angle;
                smp_ch.gps_correction <= s.gps_correction;
                smp_ch.loop_time <= s.loop_time;
                smp_ch.level_mode <= s.level_mode;
                smp_ch.blend_mode <= s.blend_mode;
                if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
            end else begin
                smp_ch.valid <= 0;
            end
        end
    end

    // Predict on acceptance.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && smp_ch.valid && smp_ch.ready;
        if (i_rst_n && smp_ch.valid && smp_ch.ready) begin
            tarp_tb_pkg::t_sample s;
            s.axis_select = smp_ch.axis_select; s.stick_command = smp_ch.stick_command;
            s.gyro_rate = smp_ch.gyro_rate; s.tilt_angle = smp_ch.tilt_angle;
            s.gps_correction = smp_ch.gps_correction; s.loop_time = smp_ch.loop_time;
            s.level_mode = smp_ch.level_mode; s.blend_mode = smp_ch.blend_mode;
            drive_q.push_back(predict_drive(s));
        end
    end

    // Monitor: checks each result beat and drives ready with stall bursts.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && drv_ch.valid && drv_ch.ready) begin
            if (drive_q.size() == 0) begin
                report_mismatch("unexpected beat", drv_ch.pid_drive, 0);
            end else begin
                tarp_tb_pkg::t_drive w;
                w = drive_q.pop_front();
                if (drv_ch.axis_done !== w.axis_done)
                    report_mismatch("axis_done", drv_ch.axis_done, w.axis_done);
                if (drv_ch.pid_drive !== w.pid_drive)
                    report_mismatch("pid_drive", drv_ch.pid_drive, w.pid_drive);
            end
        end
        if (i_rst_n && (smp_ch.valid && smp_ch.ready || drv_ch.valid && drv_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_ch.ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            drv_ch.ready <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            drv_ch.ready <= 0;
        end else begin
            drv_ch.ready <= 1;
            if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 18);
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[three_axis_rate_pid_with_level_modes_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
        smp_ch.valid = 0; smp_ch.axis_select = 0; smp_ch.stick_command = 0;
        smp_ch.gyro_rate = 0; smp_ch.tilt_angle = 0; smp_ch.gps_correction = 0;
        smp_ch.loop_time = 0; smp_ch.level_mode = 0; smp_ch.blend_mode = 0;
        drv_ch.ready = 0;
        g_p = 0; g_i = 0; g_d = 0; g_level = 0; g_rp = 0; g_yaw = 0; g_trims = 0;
        for (int k = 0; k < 3; k++) begin
            integ[k] = 0; prev_err[k] = 0; hist1[k] = 0; hist2[k] = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        write_reg(tarp_pkg::CFG_RATE_P, 32'hFFFFFF);
        write_reg(tarp_pkg::CFG_RATE_I, 32'hFFFFFF);
        write_reg(tarp_pkg::CFG_RATE_D, 32'hFFFFFF);
        write_reg(tarp_pkg::CFG_LEVEL, 32'hFFFF);
        write_reg(tarp_pkg::CFG_RP_RATES, 32'hFFFF);
        write_reg(tarp_pkg::CFG_YAW_RATE, 32'hFF);
        write_reg(tarp_pkg::CFG_TRIMS, 32'h8000_7FFF);
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        sample_q.push_back(make_sample(tarp_pkg::AXIS_ROLL, 500, -32768, -1800, 1000,
                                       65535, 0, 0));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_ROLL, -500, 32767, 1800, -1000,
                                       0, 0, 1));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_PITCH, 500, 0, 1800, 1000, 15, 1, 0));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_PITCH, -500, -1, -1800, -1000,
                                       16, 1, 1));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_YAW, 500, 32767, 0, 0, 65535, 0, 0));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_YAW, -500, -32768, -1, -1, 1, 1, 1));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_NONE, -1, -1, -1, -1, 65535, 1, 1));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_ROLL, 7, 3, -7, 0, 2000, 0, 1));
        sample_q.push_back(make_sample(tarp_pkg::AXIS_PITCH, -7, -3, 9, 0, 2000, 1, 0));
        for (int k = 0; k < 6; k++)
            sample_q.push_back(make_sample(2'(k % 3), 500, -32768, 0, 1000, 65535, 0, 0));
        wait_idle();

        write_reg(tarp_pkg::CFG_RATE_P, 0); write_reg(tarp_pkg::CFG_RATE_I, 0);
        write_reg(tarp_pkg::CFG_RATE_D, 0); write_reg(tarp_pkg::CFG_LEVEL, 0);
        write_reg(tarp_pkg::CFG_RP_RATES, 0); write_reg(tarp_pkg::CFG_YAW_RATE, 0);
        write_reg(tarp_pkg::CFG_TRIMS, 0);
        for (int k = 0; k < 10; k++) sample_q.push_back(random_sample());
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            random_regs();
            for (int k = 0; k < 200; k++) sample_q.push_back(random_sample());
            if (ph == 1) begin
                hold_cycles = 600;
            end
            if (ph == 3) calm = 1;
            wait_idle();
        end

        if (errors == 0)
            $display("[three_axis_rate_pid_with_level_modes_core] OK");
        else
            $display("[three_axis_rate_pid_with_level_modes_core] ERROR");
        $finish;
    end
endmodule
